[rtl/core/cls_pkg.sv]
package cls_pkg;

    localparam int POS_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_BYTE   = 2'd1;
    localparam logic [1:0] REQ_END    = 2'd2;
    // The remaining request code carries no meaning and is ignored.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Token types; the open-token kind uses the same codes, with zero as idle.
    localparam logic [3:0] KIND_IDLE   = 4'd0;
    localparam logic [3:0] TT_BEGIN    = 4'd0;
    localparam logic [3:0] TT_END      = 4'd1;
    localparam logic [3:0] TT_INT      = 4'd2;
    localparam logic [3:0] TT_FLOAT    = 4'd3;
    localparam logic [3:0] TT_WORD     = 4'd4;
    localparam logic [3:0] TT_HASH     = 4'd5;
    localparam logic [3:0] TT_STRING   = 4'd6;
    localparam logic [3:0] TT_COMMENT  = 4'd7;
    localparam logic [3:0] TT_MATH     = 4'd8;
    localparam logic [3:0] TT_GROUP    = 4'd9;

    typedef struct packed {
        logic [3:0]        tok_type;
        logic [15:0]       tok_start;
        logic [15:0]       tok_length;
        logic [7:0]        first_char;
        logic signed [7:0] depth;
        logic              last;
    } t_result;

    // One queue entry holds every result of one input transaction.
    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_entry;

endpackage

[rtl/core/cls_front.sv]
module cls_front #(
    parameter int POS_BITS = cls_pkg::POS_BITS_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [1:0]      i_req_type,
    input  logic [7:0]      i_in_char,
    output logic            o_wr,
    output cls_pkg::t_entry o_entry
);

    localparam int EW = (POS_BITS > 16) ? POS_BITS : 16;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic signed [7:0] NEST_MAX = 8'sd127;
    localparam logic signed [7:0] NEST_MIN = -8'sd128;

    logic [3:0]          r_kind,  n_kind;
    logic [POS_BITS-1:0] r_begin, n_begin;
    logic [POS_BITS-1:0] r_pos,   n_pos;
    logic [7:0]          r_open,  n_open;
    logic                r_hex,   n_hex;
    logic                r_esc,   n_esc;
    logic signed [7:0]   r_nest,  n_nest;

    logic                f_valid, s_valid;
    cls_pkg::t_result    f_res, s_res, flush_res;
    logic [POS_BITS-1:0] len_w, pos_inc;
    logic                cont;
    logic [7:0]          c;

    function automatic logic [15:0] fit16(input logic [POS_BITS-1:0] v);
        logic [EW-1:0] w;
        w = EW'(v);
        return w[15:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a));
    endfunction

    function automatic logic is_hexletter(input logic [7:0] ch);
        return ((ch >= 8'h61) && (ch <= 8'h66)) || ((ch >= 8'h41) && (ch <= 8'h46));
    endfunction

    function automatic logic is_math(input logic [7:0] ch);
        return (ch == 8'h3c) || (ch == 8'h3e) || (ch == 8'h3d) || (ch == 8'h2b) ||
               (ch == 8'h2d) || (ch == 8'h2a) || (ch == 8'h3f) || (ch == 8'h7c) ||
               (ch == 8'h26) || (ch == 8'h25) || (ch == 8'h5e) || (ch == 8'h3a) ||
               (ch == 8'h3b) || (ch == 8'h2c) || (ch == 8'h2e);
    endfunction

    function automatic logic is_open_br(input logic [7:0] ch);
        return (ch == 8'h28) || (ch == 8'h7b) || (ch == 8'h5b);
    endfunction

    function automatic logic is_close_br(input logic [7:0] ch);
        return (ch == 8'h29) || (ch == 8'h7d) || (ch == 8'h5d);
    endfunction

    assign c       = i_in_char;
    assign pos_inc = (&r_pos) ? r_pos : r_pos + POS_BITS'(1);
    assign len_w   = (r_pos >= r_begin) ? r_pos - r_begin : '0;

    always_comb begin
        flush_res            = '0;
        flush_res.tok_type   = r_kind;
        flush_res.tok_start  = fit16(r_begin);
        flush_res.tok_length = fit16(len_w);
        flush_res.first_char = r_open;
        flush_res.depth      = r_nest;
    end

    always_comb begin
        unique case (r_kind)
            cls_pkg::TT_WORD, cls_pkg::TT_HASH: begin
                cont = is_digit(c) || is_alpha(c) || (c == CH_HASH) || (c == CH_UNDER);
            end
            cls_pkg::TT_COMMENT: cont = (c != CH_NL);
            cls_pkg::TT_INT: begin
                cont = (c == CH_X) || (c == CH_DOT) || (r_hex && is_hexletter(c)) ||
                       is_digit(c);
            end
            cls_pkg::TT_FLOAT: cont = is_digit(c) || (c == CH_F);
            default:           cont = 1'b0;
        endcase
    end

    always_comb begin
        n_kind  = r_kind;
        n_begin = r_begin;
        n_pos   = r_pos;
        n_open  = r_open;
        n_hex   = r_hex;
        n_esc   = r_esc;
        n_nest  = r_nest;
        f_valid = 1'b0;
        s_valid = 1'b0;
        f_res   = flush_res;
        s_res   = '0;
        if (i_accept) begin
            unique case (i_req_type)
                cls_pkg::REQ_START: begin
                    n_kind  = cls_pkg::KIND_IDLE;
                    n_begin = '0;
                    n_pos   = '0;
                    n_open  = '0;
                    n_hex   = 1'b0;
                    n_esc   = 1'b0;
                    n_nest  = '0;
                    s_valid = 1'b1;
                    s_res.tok_type = cls_pkg::TT_BEGIN;
                end
                cls_pkg::REQ_END: begin
                    f_valid          = (r_kind != cls_pkg::KIND_IDLE);
                    s_valid          = 1'b1;
                    s_res.tok_type   = cls_pkg::TT_END;
                    s_res.tok_start  = fit16(r_pos);
                    s_res.depth      = r_nest;
                    n_kind  = cls_pkg::KIND_IDLE;
                    n_begin = '0;
                    n_pos   = '0;
                    n_open  = '0;
                    n_hex   = 1'b0;
                    n_esc   = 1'b0;
                    n_nest  = '0;
                end
                cls_pkg::REQ_BYTE: begin
                    n_pos = pos_inc;
                    if (r_kind == cls_pkg::TT_STRING) begin
                        priority if (r_esc) begin
                            n_esc = 1'b0;
                        end else if (c == r_open) begin
                            f_valid = 1'b1;
                            n_kind  = cls_pkg::KIND_IDLE;
                        end else if (c == CH_BSLASH) begin
                            n_esc = 1'b1;
                        end else begin
                        end
                    end else if ((r_kind != cls_pkg::KIND_IDLE) && cont) begin
                        if (r_kind == cls_pkg::TT_INT) begin
                            priority if (c == CH_X) begin
                                n_hex = 1'b1;
                            end else if (c == CH_DOT) begin
                                n_kind = cls_pkg::TT_FLOAT;
                            end else begin
                            end
                        end
                    end else begin
                        f_valid = (r_kind != cls_pkg::KIND_IDLE);
                        n_kind  = cls_pkg::KIND_IDLE;
                        if ((c != CH_SPACE) && (c != CH_TAB) && (c != CH_NL)) begin
                            n_hex  = 1'b0;
                            n_open = c;
                            s_res.tok_start  = fit16(r_pos);
                            s_res.first_char = c;
                            priority if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
                                n_kind  = cls_pkg::TT_STRING;
                                n_begin = pos_inc;
                                n_esc   = 1'b0;
                            end else if (c == CH_HASH) begin
                                n_kind  = cls_pkg::TT_HASH;
                                n_begin = pos_inc;
                            end else if (c == CH_SLASH) begin
                                n_kind  = cls_pkg::TT_COMMENT;
                                n_begin = r_pos;
                            end else if (is_open_br(c)) begin
                                n_nest         = (r_nest != NEST_MAX) ? r_nest + 8'sd1 : r_nest;
                                s_valid        = 1'b1;
                                s_res.tok_type = cls_pkg::TT_GROUP;
                                s_res.depth    = n_nest;
                            end else if (is_close_br(c)) begin
                                n_nest         = (r_nest != NEST_MIN) ? r_nest - 8'sd1 : r_nest;
                                s_valid        = 1'b1;
                                s_res.tok_type = cls_pkg::TT_GROUP;
                                s_res.depth    = n_nest;
                            end else if (is_math(c)) begin
                                s_valid          = 1'b1;
                                s_res.tok_type   = cls_pkg::TT_MATH;
                                s_res.tok_length = 16'd1;
                                s_res.depth      = r_nest;
                            end else if (is_alpha(c)) begin
                                n_kind  = cls_pkg::TT_WORD;
                                n_begin = r_pos;
                            end else if (is_digit(c)) begin
                                n_kind  = cls_pkg::TT_INT;
                                n_begin = r_pos;
                            end else begin
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Pack the results of this transaction, oldest first, into one entry.
    always_comb begin
        o_wr            = f_valid || s_valid;
        o_entry.two     = f_valid && s_valid;
        o_entry.res0    = f_valid ? f_res : s_res;
        o_entry.res0.last = !(f_valid && s_valid);
        o_entry.res1    = s_res;
        o_entry.res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= cls_pkg::KIND_IDLE;
            r_begin <= '0;
            r_pos   <= '0;
            r_open  <= '0;
            r_hex   <= 1'b0;
            r_esc   <= 1'b0;
            r_nest  <= '0;
        end else begin
            r_kind  <= n_kind;
            r_begin <= n_begin;
            r_pos   <= n_pos;
            r_open  <= n_open;
            r_hex   <= n_hex;
            r_esc   <= n_esc;
            r_nest  <= n_nest;
        end
    end

endmodule

[rtl/core/cls_queue.sv]
module cls_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  cls_pkg::t_entry i_entry,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_nonempty,
    output cls_pkg::t_entry o_entry
);

    localparam int PW = $clog2(cls_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(cls_pkg::QUEUE_DEPTH + 1);

    cls_pkg::t_entry r_mem [cls_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            wr_en, rd_en;

    assign o_full     = (r_cnt == CW'(cls_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign wr_en      = i_wr && !o_full;
    assign rd_en      = i_rd && o_nonempty;
    assign o_entry    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PW'(cls_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == PW'(cls_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[rtl/core/cls_back.sv]
module cls_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_nonempty,
    input  cls_pkg::t_entry  i_q_entry,
    output logic             o_q_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output cls_pkg::t_result o_res
);

    logic            r_valid;
    logic            r_idx;
    cls_pkg::t_entry r_entry;
    logic            take, done;

    assign take    = i_pop && r_valid;
    // The held entry is finished once its final result is taken.
    assign done    = take && !(r_entry.two && !r_idx);
    assign o_q_rd  = i_q_nonempty && (!r_valid || done);
    assign o_empty = !r_valid;
    assign o_res   = r_idx ? r_entry.res1 : r_entry.res0;

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_entry <= i_q_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            if (o_q_rd) begin
                r_valid <= 1'b1;
                r_idx   <= 1'b0;
            end else if (done) begin
                r_valid <= 1'b0;
                r_idx   <= 1'b0;
            end else if (take) begin
                r_idx   <= 1'b1;
            end
        end
    end

endmodule

[rtl/core/c_like_token_scanner.sv]
// C-like token scanner.
// Input channel: drive i_req_type and i_in_char with push high; the transaction
// is taken at a rising edge where push is high and full is low. A start request
// clears the scanner and yields a BEGIN token, each text byte advances the scan,
// and an end request flushes any open token and then yields an END token.
// Result channel: while empty is low the oldest token sits on the o_ ports; it
// is taken at a rising edge where pop is high. o_last marks the final token of
// the input transaction that caused it (one transaction yields up to two).
// Throughput: one input transaction per cycle while full is low, with the
// scanner state updated in the front stage; one token per cycle leaves the
// output register while pop is high and tokens are waiting. A token is
// written into the queue at the edge that accepts the transaction completing
// it, and the output register loads it from the queue once it is free.
// A four-entry queue sits between the scanner and the output stage, so a stalled
// receiver only backs up the queue; full rises once it holds four transactions'
// worth of tokens and input is then held off until pop frees an entry.
// Reset (synchronous, i_rst_n low) empties the queue and output stage and
// returns the scanner to its idle state with offset and depth at zero.
module c_like_token_scanner #(
    parameter int POS_BITS = cls_pkg::POS_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_in_char,
    output logic              empty,
    input  logic              pop,
    output logic [3:0]        o_tok_type,
    output logic [15:0]       o_tok_start,
    output logic [15:0]       o_tok_length,
    output logic [7:0]        o_first_char,
    output logic signed [7:0] o_depth,
    output logic              o_last
);

    logic             accept;
    logic             fe_wr;
    cls_pkg::t_entry  fe_entry;
    logic             q_full;
    logic             q_nonempty;
    logic             q_rd;
    cls_pkg::t_entry  q_entry;
    cls_pkg::t_result out_res;

    // A transaction is taken whenever the queue has room, even if the
    // transaction turns out to produce no tokens.
    assign full   = q_full;
    assign accept = push && !q_full;

    cls_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_in_char  (i_in_char),
        .o_wr       (fe_wr),
        .o_entry    (fe_entry)
    );

    cls_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (fe_wr),
        .i_entry    (fe_entry),
        .i_rd       (q_rd),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_entry    (q_entry)
    );

    cls_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_entry    (q_entry),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_res        (out_res)
    );

    assign o_tok_type   = out_res.tok_type;
    assign o_tok_start  = out_res.tok_start;
    assign o_tok_length = out_res.tok_length;
    assign o_first_char = out_res.first_char;
    assign o_depth      = out_res.depth;
    assign o_last       = out_res.last;

`ifndef NO_ASSERTIONS
    // Right after reset nothing can be waiting and input must be open.
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("output or queue not cleared by reset");

    // A BEGIN token is always alone and carries zero offset, length and depth.
    a_begin_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_tok_type == cls_pkg::TT_BEGIN)) |->
        (o_last && (o_tok_start == 16'd0) && (o_tok_length == 16'd0) && (o_depth == 8'sd0)))
        else $error("malformed BEGIN token");

    // END closes its transaction and group tokens never carry text.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((o_tok_type == cls_pkg::TT_END) || (o_tok_type == cls_pkg::TT_GROUP)))
        |-> (o_last && (o_tok_length == 16'd0)))
        else $error("END or group token malformed");

    // The output stage may not drop a token on its own: with no pop it holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_res)))
        else $error("pending token changed without pop");
`endif

endmodule
